[hw/rtl/lrsv_pkg.sv]
// Shared types, codes and the CRC-32 byte step of the log record stream validator.
package lrsv_pkg;

  localparam int unsigned HdrIdxW = 5;
  localparam logic [HdrIdxW-1:0] HDR_LAST       = HdrIdxW'(27);
  localparam logic [HdrIdxW-1:0] HDR_VERSION_AT = HdrIdxW'(4);
  localparam logic [HdrIdxW-1:0] HDR_SEQ_AT     = HdrIdxW'(8);
  localparam logic [HdrIdxW-1:0] HDR_TYPE_AT    = HdrIdxW'(16);
  localparam logic [HdrIdxW-1:0] HDR_LEN_AT     = HdrIdxW'(20);
  localparam logic [HdrIdxW-1:0] HDR_CSUM_AT    = HdrIdxW'(24);

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_MAGIC        = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_VERSION      = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_TYPE_LOWEST  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_TYPE_HIGHEST = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CFG_REPLAY_AFTER = CfgIdxW'(4);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_MAGIC     = 3'd1,
    ST_VERSION   = 3'd2,
    ST_SEQUENCE  = 3'd3,
    ST_TYPE      = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_CHECKSUM  = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_e;

  typedef struct packed {
    logic [31:0] magic_word;
    logic [31:0] format_version;
    logic [31:0] type_lowest;
    logic [31:0] type_highest;
    logic [63:0] replay_after;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [63:0] record_sequence;
    logic [31:0] record_type;
    logic [31:0] record_length;
    logic        replay_marked;
    status_e     status_code;
    logic        last_of_run;
  } res_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/lrsv_cfg_regs.sv]
// Configuration registers of the log record stream validator.
module lrsv_cfg_regs import lrsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAGIC:        cfg_d.magic_word     = cfg_wdata_i[31:0];
        CFG_VERSION:      cfg_d.format_version = cfg_wdata_i[31:0];
        CFG_TYPE_LOWEST:  cfg_d.type_lowest    = cfg_wdata_i[31:0];
        CFG_TYPE_HIGHEST: cfg_d.type_highest   = cfg_wdata_i[31:0];
        CFG_REPLAY_AFTER: cfg_d.replay_after   = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word     <= 32'd0;
      cfg_q.format_version <= 32'd1;
      cfg_q.type_lowest    <= 32'd0;
      cfg_q.type_highest   <= 32'd15;
      cfg_q.replay_after   <= 64'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/lrsv_parser.sv]
// Record deframer: header capture and checks, payload forwarding and CRC, descriptor and status results.
module lrsv_parser import lrsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       push0_o,
  output logic       push1_o,
  output res_t       res0_o,
  output res_t       res1_o
);

  typedef enum logic {
    PH_HEADER  = 1'b0,
    PH_PAYLOAD = 1'b1
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [HdrIdxW-1:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0]         magic_q, magic_d;
  logic [31:0]         version_q, version_d;
  logic [63:0]         seq_q, seq_d;
  logic [31:0]         rtype_q, rtype_d;
  logic [31:0]         len_q, len_d;
  logic [31:0]         csum_q, csum_d;
  logic [31:0]         remain_q, remain_d;
  logic [31:0]         crc_q, crc_d;
  logic [63:0]         exp_seq_q, exp_seq_d;
  status_e             err_q, err_d;

  logic [31:0] crc_n;
  logic        replay;
  logic        crc_ok;
  res_t        rec;

  assign replay = (cfg_i.replay_after == 64'd0) || (seq_d > cfg_i.replay_after);

  always_comb begin
    rec                 = '0;
    rec.kind            = KIND_RECORD;
    rec.record_sequence = seq_d;
    rec.record_type     = rtype_d;
    rec.record_length   = len_d;
    rec.replay_marked   = replay;
    rec.status_code     = ST_OK;
    rec.last_of_run     = 1'b1;
  end

  always_comb begin
    phase_d   = phase_q;
    hdr_idx_d = hdr_idx_q;
    magic_d   = magic_q;
    version_d = version_q;
    seq_d     = seq_q;
    rtype_d   = rtype_q;
    len_d     = len_q;
    csum_d    = csum_q;
    remain_d  = remain_q;
    crc_d     = crc_q;
    exp_seq_d = exp_seq_q;
    err_d     = err_q;
    push0_o   = 1'b0;
    push1_o   = 1'b0;
    res0_o    = rec;
    res1_o    = rec;
    crc_n     = crc_byte(crc_q, data_byte_i);
    crc_ok    = 1'b0;

    if (accept_i) begin
      if (end_of_file_i) begin
        res0_o             = '0;
        res0_o.kind        = KIND_STATUS;
        res0_o.last_of_run = 1'b1;
        if (err_q != ST_OK) begin
          res0_o.status_code = err_q;
        end else if (phase_q == PH_PAYLOAD || hdr_idx_q != '0) begin
          res0_o.status_code = ST_TRUNCATED;
        end else begin
          res0_o.status_code = ST_OK;
        end
        push0_o   = 1'b1;
        phase_d   = PH_HEADER;
        hdr_idx_d = '0;
        magic_d   = '0;
        version_d = '0;
        seq_d     = '0;
        rtype_d   = '0;
        len_d     = '0;
        csum_d    = '0;
        remain_d  = '0;
        crc_d     = CRC_INIT;
        exp_seq_d = 64'd1;
        err_d     = ST_OK;
      end else if (err_q == ST_OK) begin
        if (phase_q == PH_HEADER) begin
          if (hdr_idx_q < HDR_VERSION_AT) begin
            magic_d[{hdr_idx_q[1:0], 3'b000} +: 8] = data_byte_i;
          end else if (hdr_idx_q < HDR_SEQ_AT) begin
            version_d[{hdr_idx_q[1:0], 3'b000} +: 8] = data_byte_i;
          end else if (hdr_idx_q < HDR_TYPE_AT) begin
            seq_d[{hdr_idx_q[2:0], 3'b000} +: 8] = data_byte_i;
          end else if (hdr_idx_q < HDR_LEN_AT) begin
            rtype_d[{hdr_idx_q[1:0], 3'b000} +: 8] = data_byte_i;
          end else if (hdr_idx_q < HDR_CSUM_AT) begin
            len_d[{hdr_idx_q[1:0], 3'b000} +: 8] = data_byte_i;
          end else begin
            csum_d[{hdr_idx_q[1:0], 3'b000} +: 8] = data_byte_i;
          end

          if (hdr_idx_q != HDR_LAST) begin
            hdr_idx_d = hdr_idx_q + HdrIdxW'(1);
          end else begin
            hdr_idx_d = '0;
            if (magic_d != cfg_i.magic_word) begin
              err_d = ST_MAGIC;
            end else if (version_d != cfg_i.format_version) begin
              err_d = ST_VERSION;
            end else if (seq_d != exp_seq_q) begin
              err_d = ST_SEQUENCE;
            end else if (rtype_d < cfg_i.type_lowest || rtype_d > cfg_i.type_highest) begin
              err_d = ST_TYPE;
            end else begin
              crc_d    = CRC_INIT;
              remain_d = len_d;
              if (len_d == 32'd0) begin
                crc_ok             = (csum_d == 32'd0);
                push0_o            = 1'b1;
                res0_o.status_code = crc_ok ? ST_OK : ST_CHECKSUM;
              end else begin
                phase_d = PH_PAYLOAD;
              end
            end
          end
        end else begin
          crc_d               = crc_n;
          push0_o             = 1'b1;
          res0_o.kind         = KIND_PAYLOAD;
          res0_o.payload_byte = data_byte_i;
          res0_o.last_of_run  = (remain_q != 32'd1);
          remain_d            = remain_q - 32'd1;
          if (remain_q == 32'd1) begin
            crc_ok             = (~crc_n == csum_q);
            push1_o            = 1'b1;
            res1_o.status_code = crc_ok ? ST_OK : ST_CHECKSUM;
            phase_d            = PH_HEADER;
            hdr_idx_d          = '0;
            remain_d           = 32'd0;
          end
        end

        if ((push0_o && res0_o.kind == KIND_RECORD) || push1_o) begin
          if (!crc_ok) begin
            err_d = ST_CHECKSUM;
          end else if (exp_seq_q == {64{1'b1}}) begin
            err_d = ST_OVERFLOW;
          end else begin
            exp_seq_d = exp_seq_q + 64'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_idx_q <= '0;
      magic_q   <= '0;
      version_q <= '0;
      seq_q     <= '0;
      rtype_q   <= '0;
      len_q     <= '0;
      csum_q    <= '0;
      remain_q  <= '0;
      crc_q     <= CRC_INIT;
      exp_seq_q <= 64'd1;
      err_q     <= ST_OK;
    end else begin
      phase_q   <= phase_d;
      hdr_idx_q <= hdr_idx_d;
      magic_q   <= magic_d;
      version_q <= version_d;
      seq_q     <= seq_d;
      rtype_q   <= rtype_d;
      len_q     <= len_d;
      csum_q    <= csum_d;
      remain_q  <= remain_d;
      crc_q     <= crc_d;
      exp_seq_q <= exp_seq_d;
      err_q     <= err_d;
    end
  end

  a_halted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !end_of_file_i && err_q != ST_OK |-> !push0_o && !push1_o)
    else $error("result produced while halted");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_o |-> push0_o && res0_o.kind == KIND_PAYLOAD && res1_o.kind == KIND_RECORD)
    else $error("second result without payload byte before it");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_file_i |=> phase_q == PH_HEADER && hdr_idx_q == '0 && err_q == ST_OK
      && exp_seq_q == 64'd1)
    else $error("state not cleared after end of file");

  a_payload_in_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_o && res0_o.kind == KIND_PAYLOAD |-> phase_q == PH_PAYLOAD && remain_q != 32'd0)
    else $error("payload byte outside payload phase");

endmodule

[hw/rtl/lrsv_out_fifo.sv]
// Three-entry result queue; the head entry drives the output channel.
module lrsv_out_fifo import lrsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  logic push1_i,
  input  res_t res0_i,
  input  res_t res1_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t head_o,
  output logic in_stall_o
);

  localparam int unsigned Depth = 3;

  res_t       slot_q [Depth];
  res_t       slot_d [Depth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign pop  = (cnt_q != 2'd0) && !out_stall_i;
  assign base = cnt_q - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (pop && i < Depth - 1) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push0_i && base == 2'(i)) begin
        slot_d[i] = res0_i;
      end
      if (push1_i && base + 2'd1 == 2'(i)) begin
        slot_d[i] = res1_i;
      end
    end
    cnt_d = base + {1'b0, push0_i} + {1'b0, push1_i};
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = slot_q[0];
  assign in_stall_o  = (cnt_q > 2'd1);

  a_room_for_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> cnt_q <= 2'd1)
    else $error("push into queue without room for two results");

endmodule

[hw/rtl/log_record_stream_validator.sv]
// Top level of the log record stream validator.
//
// Input channel: one log file byte per transfer (data_byte_i), or an end-of-file
// marker (end_of_file_i). Output channel: one result per transfer: a forwarded
// payload byte, a record descriptor with CRC verdict and replay flag, or the
// end-of-file status. last_of_run_o marks the last result of an input transfer.
// Each accepted byte is handled in the cycle of its transfer; its results go to
// a three-entry result queue whose head drives the outputs. Throughput is one
// byte per cycle while in_stall_o is low; a payload byte that closes a record
// yields two results. in_stall_o rises once more than one result is waiting,
// as after such a byte or when the receiver stalls and the queue fills.
// Reset empties the queue, clears the parser state and loads the configuration
// defaults. Configuration writes take effect at the next edge; the user must
// make them only while no transfer is in flight; the block does not enforce it.
module log_record_stream_validator import lrsv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_file_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          payload_byte_o,
  output logic [63:0]         record_sequence_o,
  output logic [31:0]         record_type_o,
  output logic [31:0]         record_length_o,
  output logic                replay_marked_o,
  output logic [2:0]          status_code_o,
  output logic                last_of_run_o
);

  cfg_t cfg;
  logic accept;
  logic push0, push1;
  res_t res0, res1, head;

  assign accept = in_valid_i && !in_stall_o;

  lrsv_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lrsv_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .push0_o       (push0),
    .push1_o       (push1),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  lrsv_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (push0),
    .push1_i     (push1),
    .res0_i      (res0),
    .res1_i      (res1),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .head_o      (head),
    .in_stall_o  (in_stall_o)
  );

  assign kind_o            = 2'(head.kind);
  assign payload_byte_o    = head.payload_byte;
  assign record_sequence_o = head.record_sequence;
  assign record_type_o     = head.record_type;
  assign record_length_o   = head.record_length;
  assign replay_marked_o   = head.replay_marked;
  assign status_code_o     = 3'(head.status_code);
  assign last_of_run_o     = head.last_of_run;

endmodule
